/* rtl/fqs_pkg.sv */
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared types and defaults for the FIFO queue with linear search.
// ----------------------------------------------------------------------------
package fqs_pkg;

  localparam int unsigned DefDepth = 16;
  localparam int unsigned DefWidth = 32;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned DistanceW = 4;
  localparam int unsigned OccW      = 5;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_FINISH
  } state_e;

endpackage

/* rtl/fqs_req_if.sv */
// ----------------------------------------------------------------------------
// fqs_req_if
// Request channel: command and value with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fqs_req_if
  import fqs_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

/* rtl/fqs_rsp_if.sv */
// ----------------------------------------------------------------------------
// fqs_rsp_if
// Response channel: head word, match distance, status and occupancy.
// ----------------------------------------------------------------------------
interface fqs_rsp_if
  import fqs_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] data;
  logic [DistanceW-1:0]     distance;
  logic [1:0]               status;
  logic                     is_empty;
  logic [OccW-1:0]          occupancy;

  modport source (output valid, output data, output distance, output status,
                  output is_empty, output occupancy, input ready);
  modport sink   (input valid, input data, input distance, input status,
                  input is_empty, input occupancy, output ready);
endinterface

/* rtl/fifo_queue_with_search_top.sv */
// Push and error cases go from the request straight to FINISH; pop and peek
// pass through READ, and search stays in SCAN until a match or the last entry.
// One request at a time; search speed is set by the single memory read port,
// one entry per cycle. The response register frees the request side early.
// Reset clears head, tail, count and control; entry storage is not cleared.
// ----------------------------------------------------------------------------
// fifo_queue_with_search_top
// Circular FIFO in a synchronous memory with push, pop, peek and search.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_top
  import fqs_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth,
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fqs_req_if.sink    req_i,
  fqs_rsp_if.source  rsp_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e state_q, state_d;
  cmd_e   cmd_q, cmd_d;
  logic [WIDTH-1:0] key_q, key_d;
  logic [IW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [IW-1:0]    ptr_q, ptr_d, scan_q, scan_d;
  logic [CW-1:0]    count_q, count_d;

  logic [ValueW-1:0]    res_data_q, res_data_d;
  logic [DistanceW-1:0] res_dist_q, res_dist_d;
  status_e              res_status_q, res_status_d;

  logic                 out_valid_q, out_valid_d;
  logic [ValueW-1:0]    out_data_q;
  logic [DistanceW-1:0] out_dist_q;
  status_e              out_status_q;
  logic                 out_empty_q;
  logic [OccW-1:0]      out_occ_q;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic             rd_en, mem_we;
  logic [IW-1:0]    rd_addr;
  logic [WIDTH-1:0] wdata;

  logic req_fire, out_load, is_full, scan_hit, scan_last;
  cmd_e req_cmd;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
    next_idx = (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign req_cmd   = cmd_e'(req_i.cmd);
  assign req_fire  = req_i.valid && (state_q == S_IDLE);
  assign out_load  = (state_q == S_FINISH) && (!out_valid_q || rsp_o.ready);
  assign is_full   = (count_q == CW'(DEPTH));
  assign scan_hit  = (rdata_q == key_q);
  assign scan_last = ((CW'(scan_q) + CW'(1)) == count_q);
  assign wdata     = WIDTH'($unsigned(req_i.value));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          case (req_cmd)
            CMD_PUSH:          state_d = S_FINISH;
            CMD_POP, CMD_PEEK: state_d = (count_q == '0) ? S_FINISH : S_READ;
            CMD_SEARCH:        state_d = (count_q == '0) ? S_FINISH : S_SCAN;
            default:           state_d = S_FINISH;
          endcase
        end
      end
      S_READ:   state_d = S_FINISH;
      S_SCAN: begin
        if (scan_hit || scan_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready  = (state_q == S_IDLE);
    cmd_d        = cmd_q;
    key_d        = key_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    scan_d       = scan_q;
    res_data_d   = res_data_q;
    res_dist_d   = res_dist_q;
    res_status_d = res_status_q;
    rd_en        = 1'b0;
    rd_addr      = head_q;
    mem_we       = 1'b0;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          cmd_d        = req_cmd;
          key_d        = wdata;
          res_data_d   = '0;
          res_dist_d   = '0;
          res_status_d = ST_OK;
          case (req_cmd)
            CMD_PUSH: begin
              if (is_full) begin
                res_status_d = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                tail_d  = next_idx(tail_q);
                count_d = count_q + 1'b1;
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                rd_en = 1'b1;
              end
            end
            CMD_SEARCH: begin
              if (count_q == '0) begin
                res_status_d = ST_NOTFOUND;
              end else begin
                rd_en  = 1'b1;
                scan_d = '0;
                ptr_d  = next_idx(head_q);
              end
            end
            default: res_status_d = ST_OK;
          endcase
        end
      end
      S_READ: begin
        res_data_d = ValueW'($signed(rdata_q));
        if (cmd_q == CMD_POP) begin
          head_d  = next_idx(head_q);
          count_d = count_q - 1'b1;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          res_dist_d = DistanceW'(scan_q);
        end else if (scan_last) begin
          res_status_d = ST_NOTFOUND;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_q;
          ptr_d   = next_idx(ptr_q);
          scan_d  = scan_q + 1'b1;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          out_valid_d = 1'b1;
        end
      end
      default: out_valid_d = out_valid_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    ptr_q        <= ptr_d;
    scan_q       <= scan_d;
    res_data_q   <= res_data_d;
    res_dist_q   <= res_dist_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_data_q   <= res_data_q;
      out_dist_q   <= res_dist_q;
      out_status_q <= res_status_q;
      out_empty_q  <= (count_q == '0);
      out_occ_q    <= OccW'(count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.data      = out_data_q;
  assign rsp_o.distance  = out_dist_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.is_empty  = out_empty_q;
  assign rsp_o.occupancy = out_occ_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty queue with head and tail apart");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && (req_cmd == CMD_PUSH) && !is_full) |=>
      (count_q == $past(count_q) + 1'b1))
    else $error("push did not advance count");

  a_tail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> $stable(tail_q))
    else $error("tail moved outside a push request");
`endif

endmodule
